// ===== design/motor_speed_pid_pwm_unit_macros.svh =====
// Assertion macros for the motor speed PID/PWM unit checker.
// Clock and active-low reset are passed in; no other dependencies.
`ifndef MOTOR_SPEED_PID_PWM_UNIT_MACROS_SVH
`define MOTOR_SPEED_PID_PWM_UNIT_MACROS_SVH

// Same-cycle implication
`define MSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msp_pkg.sv =====
// Shared types and register indexes for the motor speed PID/PWM unit.
// No dependencies; imported by every design module except msp_checker, and by the testbench.
package msp_pkg;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_KP_GAIN = 3'd0;
    localparam logic [2:0] REG_KI_GAIN = 3'd1;
    localparam logic [2:0] REG_KD_GAIN = 3'd2;
    localparam logic [2:0] REG_LOW_TP  = 3'd3;
    localparam logic [2:0] REG_MID_TP  = 3'd4;
    localparam logic [2:0] REG_FLOOR   = 3'd5;
    localparam logic [2:0] REG_CEILING = 3'd6;

    // What a sample does once it reaches the state updates
    typedef enum logic [1:0] {
        KIND_OFF,
        KIND_HIGH,
        KIND_RUN,
        KIND_CLEAR
    } kind_t;

    // Configuration register file contents
    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [14:0] low_target_period;
        logic [14:0] middle_target_period;
        logic [7:0]  pwm_floor;
        logic [7:0]  pwm_ceiling;
    } cfg_t;

    // Stage 1 word: gain products of the error
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic signed [33:0] p_term;
        logic signed [33:0] i_term;
        logic signed [34:0] d_term;
    } prod_t;

    // Stage 2 word: correction as sign and magnitude
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic        neg;
        logic        big;
        logic [27:0] mag;
    } corr_t;

endpackage

// ===== design/msp_regs.sv =====
// APB configuration registers (gains, target periods, PWM limits).
// Depends on msp_pkg for cfg_t and the register indexes.
module msp_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output msp_pkg::cfg_t cfg
);
    import msp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_KP_GAIN: cfg_next.kp_gain              = pwdata[15:0];
                REG_KI_GAIN: cfg_next.ki_gain              = pwdata[15:0];
                REG_KD_GAIN: cfg_next.kd_gain              = pwdata[15:0];
                REG_LOW_TP:  cfg_next.low_target_period    = pwdata[14:0];
                REG_MID_TP:  cfg_next.middle_target_period = pwdata[14:0];
                REG_FLOOR:   cfg_next.pwm_floor            = pwdata[7:0];
                REG_CEILING: cfg_next.pwm_ceiling          = pwdata[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_KP_GAIN: prdata = {16'd0, cfg_reg.kp_gain};
            REG_KI_GAIN: prdata = {16'd0, cfg_reg.ki_gain};
            REG_KD_GAIN: prdata = {16'd0, cfg_reg.kd_gain};
            REG_LOW_TP:  prdata = {17'd0, cfg_reg.low_target_period};
            REG_MID_TP:  prdata = {17'd0, cfg_reg.middle_target_period};
            REG_FLOOR:   prdata = {24'd0, cfg_reg.pwm_floor};
            REG_CEILING: prdata = {24'd0, cfg_reg.pwm_ceiling};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain              <= 16'd52429;
            cfg_reg.ki_gain              <= 16'd655;
            cfg_reg.kd_gain              <= 16'd5243;
            cfg_reg.low_target_period    <= 15'd160;
            cfg_reg.middle_target_period <= 15'd80;
            cfg_reg.pwm_floor            <= 8'd6;
            cfg_reg.pwm_ceiling          <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/msp_front.sv =====
// Stage 1: speed error, previous-error state and the three gain products.
// Depends on msp_pkg for cfg_t, kind_t and prod_t.
module msp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           motor_enabled,
    input  logic [1:0]     speed_mode,
    input  logic [14:0]    rotation_period,
    input  logic           move_requested,
    input  msp_pkg::cfg_t  cfg,
    input  logic           down_ready,
    output logic           in_ready,
    output msp_pkg::prod_t s1
);
    import msp_pkg::*;

    kind_t              kind;
    logic [14:0]        target;
    logic signed [16:0] err;
    logic signed [17:0] diff;
    logic signed [16:0] last_error_reg;
    logic signed [16:0] last_error_next;
    prod_t              s1_reg;
    prod_t              s1_next;
    logic               accept;

    // Classify the sample; mode three behaves as high
    always_comb
    begin
        if (!motor_enabled)
            kind = KIND_OFF;
        else if (speed_mode[1])
            kind = KIND_HIGH;
        else if (rotation_period != 15'd0 && move_requested)
            kind = KIND_RUN;
        else
            kind = KIND_CLEAR;
    end

    // Error and its change since the previous run sample
    assign target = speed_mode[0] ? cfg.middle_target_period : cfg.low_target_period;
    assign err    = $signed({2'b00, rotation_period}) - $signed({2'b00, target});
    assign diff   = $signed({err[16], err}) - $signed({last_error_reg[16], last_error_reg});

    // Gain products
    always_comb
    begin
        s1_next.valid  = in_valid;
        s1_next.kind   = kind;
        s1_next.p_term = $signed({1'b0, cfg.kp_gain}) * err;
        s1_next.i_term = $signed({1'b0, cfg.ki_gain}) * err;
        s1_next.d_term = $signed({1'b0, cfg.kd_gain}) * diff;
    end

    // Previous error follows run samples, clears on idle samples
    always_comb
    begin
        case (kind)
            KIND_RUN:   last_error_next = err;
            KIND_CLEAR: last_error_next = '0;
            default:    last_error_next = last_error_reg;
        endcase
    end

    assign in_ready = !s1_reg.valid || down_ready;
    assign accept   = in_valid && in_ready;
    assign s1       = s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (in_ready)
                s1_reg <= s1_next;
            if (accept)
                last_error_reg <= last_error_next;
        end
    end

endmodule

// ===== design/msp_accum.sv =====
// Stage 2: saturating integral accumulator and PID correction sum.
// Depends on msp_pkg for kind_t, prod_t and corr_t.
module msp_accum (
    input  logic           clk,
    input  logic           rst_n,
    input  msp_pkg::prod_t s1,
    input  logic           down_ready,
    output logic           up_ready,
    output msp_pkg::corr_t s2
);
    import msp_pkg::*;

    localparam logic signed [40:0] SAT_MAX   = 41'sd549755813887;
    localparam logic signed [40:0] SAT_MIN   = -41'sd549755813888;
    // |correction| at or above this moves the level by 2^24 or more
    localparam logic [41:0]        DIV_LIMIT = 42'd167772160;

    logic signed [39:0] integral_reg;
    logic signed [39:0] integral_next;
    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic signed [41:0] corr;
    logic [41:0]        mag;
    corr_t              s2_reg;
    corr_t              s2_next;
    logic               fire;

    // Integral plus ki*err, clipped to 40 bits
    always_comb
    begin
        acc_sum = $signed({integral_reg[39], integral_reg})
                + $signed({{7{s1.i_term[33]}}, s1.i_term});
        if (acc_sum > SAT_MAX)
            acc_sat = {1'b0, {39{1'b1}}};
        else if (acc_sum < SAT_MIN)
            acc_sat = {1'b1, 39'd0};
        else
            acc_sat = acc_sum[39:0];
    end

    always_comb
    begin
        case (s1.kind)
            KIND_RUN:   integral_next = acc_sat;
            KIND_CLEAR: integral_next = '0;
            default:    integral_next = integral_reg;
        endcase
    end

    // Correction and its magnitude for the divide
    always_comb
    begin
        corr = $signed({{2{integral_next[39]}}, integral_next})
             + $signed({{8{s1.p_term[33]}}, s1.p_term})
             + $signed({{7{s1.d_term[34]}}, s1.d_term});
        mag  = corr[41] ? (42'd0 - corr) : corr;
        s2_next.valid = s1.valid;
        s2_next.kind  = s1.kind;
        s2_next.neg   = corr[41];
        s2_next.big   = (mag >= DIV_LIMIT);
        s2_next.mag   = mag[27:0];
    end

    assign up_ready = !s2_reg.valid || down_ready;
    assign fire     = s1.valid && up_ready;
    assign s2       = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg       <= '0;
            integral_reg <= '0;
        end
        else
        begin
            if (up_ready)
                s2_reg <= s2_next;
            if (fire)
                integral_reg <= integral_next;
        end
    end

endmodule

// ===== design/msp_level.sv =====
// Stages 3 and 4: divide by ten, duty level update with clamp, result register.
// Depends on msp_pkg for cfg_t, kind_t and corr_t.
module msp_level (
    input  logic           clk,
    input  logic           rst_n,
    input  msp_pkg::corr_t s2,
    input  msp_pkg::cfg_t  cfg,
    input  logic           out_ready,
    output logic           up_ready,
    output logic           out_valid,
    output logic           width_written,
    output logic [7:0]     pwm_width
);
    import msp_pkg::*;

    // ceil(2^31 / 10): exact quotient for magnitudes below 2^30
    localparam logic [27:0] RECIP       = 28'd214748365;
    localparam int          RECIP_SHIFT = 31;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic        neg;
        logic        big;
        logic [23:0] quo;
    } quot_t;

    logic [55:0]        recip_prod;
    quot_t              s3_reg;
    quot_t              s3_next;
    logic               out_open;
    logic               fire;
    logic [23:0]        level_reg;
    logic [23:0]        level_next;
    logic [23:0]        run_level;
    logic [23:0]        lo;
    logic [23:0]        hi;
    logic [25:0]        delta;
    logic signed [25:0] lvl_sum;
    logic [7:0]         ipart;
    logic               out_valid_reg;
    logic               width_written_reg;
    logic               width_written_next;
    logic [7:0]         pwm_width_reg;
    logic [7:0]         pwm_width_next;

    // Divide magnitude by ten via reciprocal multiply
    assign recip_prod = s2.mag * RECIP;

    always_comb
    begin
        s3_next.valid = s2.valid;
        s3_next.kind  = s2.kind;
        s3_next.neg   = s2.neg;
        s3_next.big   = s2.big;
        s3_next.quo   = recip_prod[RECIP_SHIFT +: 24];
    end

    // Level plus truncated correction, clamped floor first
    assign lo      = {cfg.pwm_floor, 16'd0};
    assign hi      = {cfg.pwm_ceiling, 16'd0};
    assign delta   = s3_reg.neg ? (26'd0 - {2'b00, s3_reg.quo}) : {2'b00, s3_reg.quo};
    assign lvl_sum = $signed({2'b00, level_reg}) + $signed(delta);

    always_comb
    begin
        if (s3_reg.big)
            run_level = s3_reg.neg ? lo : hi;
        else if (lvl_sum < $signed({2'b00, lo}))
            run_level = lo;
        else if (lvl_sum > $signed({2'b00, hi}))
            run_level = hi;
        else
            run_level = lvl_sum[23:0];
    end

    always_comb
    begin
        case (s3_reg.kind)
            KIND_HIGH: level_next = hi;
            KIND_RUN:  level_next = run_level;
            default:   level_next = level_reg;
        endcase
    end

    // Result: high writes ceiling, off never, others if integer part in limits
    assign ipart = level_next[23:16];

    always_comb
    begin
        width_written_next = 1'b0;
        pwm_width_next     = 8'd0;
        case (s3_reg.kind)
            KIND_OFF:
            begin
                width_written_next = 1'b0;
                pwm_width_next     = 8'd0;
            end
            KIND_HIGH:
            begin
                width_written_next = 1'b1;
                pwm_width_next     = cfg.pwm_ceiling;
            end
            default:
            begin
                if (ipart >= cfg.pwm_floor && ipart <= cfg.pwm_ceiling)
                begin
                    width_written_next = 1'b1;
                    pwm_width_next     = ipart;
                end
            end
        endcase
    end

    assign out_open      = !out_valid_reg || out_ready;
    assign up_ready      = !s3_reg.valid || out_open;
    assign fire          = s3_reg.valid && out_open;
    assign out_valid     = out_valid_reg;
    assign width_written = width_written_reg;
    assign pwm_width     = pwm_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg            <= '0;
            level_reg         <= '0;
            out_valid_reg     <= 1'b0;
            width_written_reg <= 1'b0;
            pwm_width_reg     <= 8'd0;
        end
        else
        begin
            if (up_ready)
                s3_reg <= s3_next;
            if (out_open)
                out_valid_reg <= s3_reg.valid;
            if (fire)
            begin
                level_reg         <= level_next;
                width_written_reg <= width_written_next;
                pwm_width_reg     <= pwm_width_next;
            end
        end
    end

endmodule

// ===== design/motor_speed_pid_pwm_unit.sv =====
// Motor speed PID/PWM unit: incremental PID on rotation period driving a duty level.
// Pipeline: front (s1), accum (s2) and level (s3) registers, then the result register.
// Throughput: one sample per cycle with no stall; set by integral and level update loops.
// Reset (rst_n, async, active low): gains/targets/limits to defaults, state zero, pipe empty.
// Depends on msp_pkg, msp_regs, msp_front, msp_accum and msp_level.
module motor_speed_pid_pwm_unit (
    input  logic        clk,
    input  logic        rst_n,
    // sample channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        motor_enabled,
    input  logic [1:0]  speed_mode,
    input  logic [14:0] rotation_period,
    input  logic        move_requested,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        width_written,
    output logic [7:0]  pwm_width,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msp_pkg::*;

    cfg_t  cfg;
    prod_t s1;
    corr_t s2;
    logic  s2_ready;
    logic  s3_ready;

    msp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .motor_enabled   (motor_enabled),
        .speed_mode      (speed_mode),
        .rotation_period (rotation_period),
        .move_requested  (move_requested),
        .cfg             (cfg),
        .down_ready      (s2_ready),
        .in_ready        (in_ready),
        .s1              (s1)
    );

    msp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1         (s1),
        .down_ready (s3_ready),
        .up_ready   (s2_ready),
        .s2         (s2)
    );

    msp_level u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .s2            (s2),
        .cfg           (cfg),
        .out_ready     (out_ready),
        .up_ready      (s3_ready),
        .out_valid     (out_valid),
        .width_written (width_written),
        .pwm_width     (pwm_width)
    );

endmodule

// ===== design/msp_checker.sv =====
// Port-level checker for motor_speed_pid_pwm_unit, attached by bind.
// Depends on motor_speed_pid_pwm_unit_macros.svh.
`include "motor_speed_pid_pwm_unit_macros.svh"

module msp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       width_written,
    input logic [7:0] pwm_width
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    // Words in flight: at most one per pipeline register
    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
            cnt_next = cnt_reg + 3'd1;
        else if (out_acc && !in_acc)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    `MSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pwm_width) && $stable(width_written), "result word changed while stalled")
    `MSP_ASSERT_IMP(a_no_write_zero, clk, rst_n, out_valid && !width_written, pwm_width == 8'd0, "width nonzero on a no-write result")
    `MSP_ASSERT_IMP(a_out_has_source, clk, rst_n, out_valid, cnt_reg != 3'd0, "result word with no sample in flight")
    `MSP_ASSERT_IMP(a_full_when_blocked, clk, rst_n, !in_ready, cnt_reg == 3'd4, "input blocked while pipeline has room")

endmodule

bind motor_speed_pid_pwm_unit msp_checker u_msp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .width_written (width_written),
    .pwm_width     (pwm_width)
);

// ===== tb/sv/motor_speed_pid_pwm_unit_tb.sv =====
// Testbench for motor_speed_pid_pwm_unit: directed and random speed samples checked against
// fixed expectations or a cycle-free predictor of the PID duty level, with APB register phases.
// Depends on msp_pkg (cfg_t, register indexes) and the unit's RTL.
module motor_speed_pid_pwm_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    // Speed mode codes
    localparam logic [1:0] MODE_LOW   = 2'd0;
    localparam logic [1:0] MODE_MID   = 2'd1;
    localparam logic [1:0] MODE_HIGH  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int N_REGS   = 7;

    localparam longint INT40_TOP    = (longint'(1) <<< 39) - 1;
    localparam longint INT40_BOTTOM = -(longint'(1) <<< 39);

    typedef struct packed {
        logic       written;
        logic [7:0] width;
    } pwm_result_t;

    typedef struct packed {
        logic        en;
        logic [1:0]  mode;
        logic [14:0] period;
        logic        mv;
        logic        fixed;
        logic        written;
        logic [7:0]  width;
    } sample_row_t;

    typedef enum int {STIM_MIX, STIM_SAT_UP, STIM_SAT_DOWN} stim_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        motor_enabled = 1'b0;
    logic [1:0]  speed_mode = MODE_LOW;
    logic [14:0] rotation_period = '0;
    logic        move_requested = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        width_written;
    logic [7:0]  pwm_width;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Typed expectation travelling with the word on the sample channel
    logic        row_fixed = 1'b0;
    pwm_result_t row_expect = '0;

    // Register shadow and controller state
    cfg_t        cfg_shadow = '{kp_gain: 16'd52429, ki_gain: 16'd655, kd_gain: 16'd5243,
                                low_target_period: 15'd160, middle_target_period: 15'd80,
                                pwm_floor: 8'd6, pwm_ceiling: 8'd255};
    logic [23:0] level_q16 = '0;
    longint      integral_q16 = 0;
    longint      prev_error = 0;

    pwm_result_t expected_widths [$];
    int          mismatches = 0;
    bit          no_gaps = 1'b0;

    motor_speed_pid_pwm_unit dut (.*);

    always #6 clk = ~clk;

    // Directed words, run with reset register values
    sample_row_t opening_rows [24] = '{
        '{1, MODE_LOW,   0,     0, 1, 0, 0},     // level zero, below floor: no write
        '{0, MODE_LOW,   32767, 1, 1, 0, 0},     // motor off
        '{1, MODE_LOW,   160,   1, 0, 0, 0},     // zero error, clamps up to floor
        '{1, MODE_MID,   1,     1, 0, 0, 0},
        '{0, MODE_HIGH,  5,     1, 1, 0, 0},     // off wins over high mode
        '{1, MODE_HIGH,  0,     0, 1, 1, 255},   // high mode forces ceiling
        '{1, MODE_SPARE, 32767, 1, 1, 1, 255},   // spare mode acts as high
        '{1, MODE_LOW,   0,     1, 1, 1, 255},   // no period: clear, level kept
        '{1, MODE_MID,   32767, 0, 1, 1, 255},   // no request: clear, level kept
        '{1, MODE_LOW,   32767, 1, 1, 1, 255},   // largest error, held at ceiling
        '{1, MODE_MID,   32767, 1, 1, 1, 255},
        '{1, MODE_LOW,   1,     1, 0, 0, 0},     // shortest period pulls level down
        '{1, MODE_LOW,   1,     1, 0, 0, 0},
        '{1, MODE_LOW,   1,     1, 0, 0, 0},
        '{1, MODE_LOW,   1,     1, 0, 0, 0},
        '{1, MODE_LOW,   1,     1, 0, 0, 0},
        '{1, MODE_MID,   1,     1, 0, 0, 0},
        '{1, MODE_MID,   80,    1, 0, 0, 0},
        '{1, MODE_LOW,   170,   1, 0, 0, 0},
        '{1, MODE_MID,   90,    1, 0, 0, 0},
        '{1, MODE_LOW,   16384, 1, 0, 0, 0},
        '{1, MODE_MID,   21845, 1, 0, 0, 0},
        '{1, MODE_LOW,   10922, 1, 0, 0, 0},
        '{0, MODE_SPARE, 0,     0, 1, 0, 0}
    };

    // Register settings per phase: kp, ki, kd, low, mid, floor, ceiling
    localparam int N_PHASES = 8;
    int phase_regs [N_PHASES][N_REGS] = '{
        '{52429, 655,   5243,  160,   80,    6,   255},
        '{65535, 65535, 65535, 0,     32767, 0,   255},
        '{0,     0,     0,     32767, 0,     200, 50},
        '{13107, 3000,  20000, 500,   1000,  255, 255},
        '{65535, 65535, 65535, 0,     0,     0,   255},
        '{65535, 65535, 65535, 32767, 32767, 0,   255},
        '{1,     1,     1,     1,     32766, 0,   0},
        '{52429, 655,   5243,  160,   80,    6,   255}
    };
    int phase_words [N_PHASES] = '{150, 100, 80, 60, 300, 300, 50, 50};
    stim_style_t phase_style [N_PHASES] = '{STIM_MIX, STIM_MIX, STIM_MIX, STIM_MIX,
                                            STIM_SAT_UP, STIM_SAT_DOWN, STIM_MIX, STIM_MIX};

    // One step of the speed controller: updates the state and returns the result word
    function automatic pwm_result_t predict_pwm(logic en, logic [1:0] mode,
                                                logic [14:0] period, logic mv);
        pwm_result_t res;
        longint      err, corr, lvl, lo, hi, tgt, per;
        logic [7:0]  ipart;
        res = '0;
        if (!en)
            return res;
        if (mode == MODE_HIGH || mode == MODE_SPARE)
        begin
            level_q16 = {cfg_shadow.pwm_ceiling, 16'h0000};
            res.written = 1'b1;
            res.width = cfg_shadow.pwm_ceiling;
            return res;
        end
        if (period != 0 && mv)
        begin
            per = period;
            tgt = (mode == MODE_LOW) ? cfg_shadow.low_target_period
                                     : cfg_shadow.middle_target_period;
            err = per - tgt;
            // saturating integral in Q16 units
            integral_q16 = integral_q16 + longint'(cfg_shadow.ki_gain) * err;
            if (integral_q16 > INT40_TOP)
                integral_q16 = INT40_TOP;
            else if (integral_q16 < INT40_BOTTOM)
                integral_q16 = INT40_BOTTOM;
            corr = integral_q16 + longint'(cfg_shadow.kp_gain) * err
                 + longint'(cfg_shadow.kd_gain) * (err - prev_error);
            lvl = longint'(level_q16) + corr / 10;
            lo = longint'(cfg_shadow.pwm_floor) <<< 16;
            hi = longint'(cfg_shadow.pwm_ceiling) <<< 16;
            // floor test first, so with floor above ceiling a level below the floor lands on the floor
            if (lvl < lo)
                lvl = lo;
            else if (lvl > hi)
                lvl = hi;
            level_q16 = lvl[23:0];
            prev_error = err;
        end
        else
        begin
            integral_q16 = 0;
            prev_error = 0;
        end
        ipart = level_q16[23:16];
        if (ipart >= cfg_shadow.pwm_floor && ipart <= cfg_shadow.pwm_ceiling)
        begin
            res.written = 1'b1;
            res.width = ipart;
        end
        return res;
    endfunction

    function automatic logic [31:0] shadow_value(int idx);
        case (idx)
            REG_KP_GAIN: return 32'(cfg_shadow.kp_gain);
            REG_KI_GAIN: return 32'(cfg_shadow.ki_gain);
            REG_KD_GAIN: return 32'(cfg_shadow.kd_gain);
            REG_LOW_TP:  return 32'(cfg_shadow.low_target_period);
            REG_MID_TP:  return 32'(cfg_shadow.middle_target_period);
            REG_FLOOR:   return 32'(cfg_shadow.pwm_floor);
            default:     return 32'(cfg_shadow.pwm_ceiling);
        endcase
    endfunction

    function automatic int pick_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 15));
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // APB write: setup phase, access phase, then back to idle
    task automatic reg_write(int idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KP_GAIN: cfg_shadow.kp_gain = val[15:0];
            REG_KI_GAIN: cfg_shadow.ki_gain = val[15:0];
            REG_KD_GAIN: cfg_shadow.kd_gain = val[15:0];
            REG_LOW_TP:  cfg_shadow.low_target_period = val[14:0];
            REG_MID_TP:  cfg_shadow.middle_target_period = val[14:0];
            REG_FLOOR:   cfg_shadow.pwm_floor = val[7:0];
            default:     cfg_shadow.pwm_ceiling = val[7:0];
        endcase
        @(posedge clk);
    endtask

    // APB read, checked against the shadow
    task automatic reg_check(int idx);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 5'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== shadow_value(idx))
            flag_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                    idx, got, shadow_value(idx)));
        @(posedge clk);
    endtask

    // Present one sample word and hold it until accepted
    task automatic send_sample(logic en, logic [1:0] mode, logic [14:0] period, logic mv,
                               logic fixed, pwm_result_t expv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        motor_enabled <= en;
        speed_mode <= mode;
        rotation_period <= period;
        move_requested <= mv;
        row_fixed <= fixed;
        row_expect <= expv;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_widths.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Predict on accepted samples, compare accepted results
    always @(posedge clk)
    begin : watch_words
        pwm_result_t calc;
        pwm_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                calc = predict_pwm(motor_enabled, speed_mode, rotation_period,
                                   move_requested);
                expected_widths.push_back(row_fixed ? row_expect : calc);
            end
            if (out_valid && out_ready)
            begin
                if (expected_widths.size() == 0)
                    flag_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_widths.pop_front();
                    if (width_written !== want.written)
                        flag_mismatch($sformatf("width_written %b, expected %b",
                                                width_written, want.written));
                    if (pwm_width !== want.width)
                        flag_mismatch($sformatf("pwm_width %0d, expected %0d",
                                                pwm_width, want.width));
                end
            end
        end
    end

    // Result side: random stall before each word
    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int          r;
        int          p;
        int          tgt;
        logic        en;
        logic        mv;
        logic [1:0]  mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        for (int i = 0; i < N_REGS; i++)
            reg_check(i);

        for (int i = 0; i < 24; i++)
            send_sample(opening_rows[i].en, opening_rows[i].mode, opening_rows[i].period,
                        opening_rows[i].mv, opening_rows[i].fixed,
                        '{written: opening_rows[i].written, width: opening_rows[i].width});
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            for (int i = 0; i < N_REGS; i++)
            begin
                reg_write(i, 32'(phase_regs[ph][i]));
                reg_check(i);
            end
            for (int n = 0; n < phase_words[ph]; n++)
            begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                en = 1'b1;
                mv = 1'b1;
                mode = 2'($urandom_range(MODE_LOW, MODE_MID));
                tgt = (mode == MODE_LOW) ? cfg_shadow.low_target_period
                                         : cfg_shadow.middle_target_period;
                if (phase_style[ph] == STIM_MIX)
                begin
                    // mostly near the target, sometimes anywhere
                    if ($urandom_range(0, 3) != 0)
                        p = tgt + int'($urandom_range(0, 128)) - 64;
                    else
                        p = $urandom_range(1, 32767);
                    if (p < 1)
                        p = 1;
                    if (p > 32767)
                        p = 32767;
                end
                else if (phase_style[ph] == STIM_SAT_UP)
                    p = $urandom_range(30000, 32767);
                else
                    p = $urandom_range(1, 1500);
                // the integral only builds up over unbroken runs
                if (phase_style[ph] != STIM_MIX && r >= 95 && r < 98)
                begin
                    if ($urandom_range(0, 1))
                        en = 1'b0;
                    else
                        mode = 2'($urandom_range(MODE_HIGH, MODE_SPARE));
                end
                else if ((phase_style[ph] == STIM_MIX && r >= 78) || r >= 98)
                begin
                    en = ($urandom_range(0, 3) != 0);
                    mode = 2'($urandom_range(MODE_LOW, MODE_SPARE));
                    p = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 32767));
                    mv = 1'($urandom_range(0, 1));
                end
                send_sample(en, mode, 15'(p), mv, 1'b0, '0);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/msp_pkg.sv
design/msp_regs.sv
design/msp_front.sv
design/msp_accum.sv
design/msp_level.sv
design/motor_speed_pid_pwm_unit.sv
design/msp_checker.sv
tb/sv/motor_speed_pid_pwm_unit_tb.sv
